>>> hdl/elx_pkg.sv
// Shared types, constants and character classes of the expression lexer.
`timescale 1ns / 1ps
package elx_pkg;

    localparam int POS_W = 20;
    localparam int KIND_W = 5;
    localparam int CODE_W = 2;
    localparam int NKEYS = 7;
    localparam int MAX_INPUT_BYTES_DEF = 1048576;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Input opcodes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Token kinds.
    localparam logic [KIND_W-1:0] K_NUMBER = 5'd0;
    localparam logic [KIND_W-1:0] K_STRING = 5'd1;
    localparam logic [KIND_W-1:0] K_IDENT  = 5'd2;
    localparam logic [KIND_W-1:0] K_LBRACE = 5'd8;
    localparam logic [KIND_W-1:0] K_RBRACE = 5'd9;
    localparam logic [KIND_W-1:0] K_LPAREN = 5'd10;
    localparam logic [KIND_W-1:0] K_RPAREN = 5'd11;
    localparam logic [KIND_W-1:0] K_LBRACK = 5'd12;
    localparam logic [KIND_W-1:0] K_RBRACK = 5'd13;
    localparam logic [KIND_W-1:0] K_COLON  = 5'd14;
    localparam logic [KIND_W-1:0] K_EQUALS = 5'd15;
    localparam logic [KIND_W-1:0] K_EOF    = 5'd18;
    localparam logic [KIND_W-1:0] K_ERROR  = 5'd19;

    // Error codes.
    localparam logic [CODE_W-1:0] ERR_NONE         = 2'd0;
    localparam logic [CODE_W-1:0] ERR_UNEXPECTED   = 2'd1;
    localparam logic [CODE_W-1:0] ERR_UNTERMINATED = 2'd2;

    // Keyword text, left-justified, with lengths and kinds.
    localparam logic [47:0] KEY_STR [NKEYS] = '{
        {"if", 32'h0}, {"lambda"}, {"let", 24'h0}, {"in", 32'h0},
        {"end", 24'h0}, {"true", 16'h0}, {"false", 8'h0}
    };
    localparam logic [2:0] KEY_LEN [NKEYS] = '{3'd2, 3'd6, 3'd3, 3'd2, 3'd3, 3'd4, 3'd5};
    localparam logic [KIND_W-1:0] KEY_KIND [NKEYS] = '{
        5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd16, 5'd17
    };

    // One result as the front end records it; the length is finished later.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  start_off;
        logic [POS_W-1:0]  end_off;
        logic              len_one;
        logic [POS_W-1:0]  line;
        logic [POS_W-1:0]  col;
    } elx_rec_t;

    // All results of one request: one or two.
    typedef struct packed {
        logic     pair;
        elx_rec_t rec0;
        elx_rec_t rec1;
    } elx_entry_t;

    typedef struct packed {
        logic       push;
        elx_entry_t entry;
    } elx_wr_t;

    typedef struct packed {
        logic       avail;
        elx_entry_t head;
    } elx_qstat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic ident_first(input logic [7:0] c);
        return is_alpha(c) || c == "_" || c == "+" || c == "*" || c == "/" ||
               c == "<" || c == ">" || c == "?" || c == "!";
    endfunction

    function automatic logic ident_more(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_" || c == "-" || c == "?" ||
               c == "!" || c == "+" || c == "*" || c == "/" || c == "<" ||
               c == "=" || c == ">";
    endfunction

    // Returns the punctuation kind in the low bits; the top bit flags a match.
    function automatic logic [KIND_W:0] punct_kind(input logic [7:0] c);
        logic [KIND_W:0] r;
        unique case (c)
            "{":     r = {1'b1, K_LBRACE};
            "}":     r = {1'b1, K_RBRACE};
            "(":     r = {1'b1, K_LPAREN};
            ")":     r = {1'b1, K_RPAREN};
            "[":     r = {1'b1, K_LBRACK};
            "]":     r = {1'b1, K_RBRACK};
            ":":     r = {1'b1, K_COLON};
            "=":     r = {1'b1, K_EQUALS};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] key_char(input int i, input logic [2:0] k);
        logic [47:0] s;
        logic [7:0]  r;
        s = KEY_STR[i];
        unique case (k)
            3'd0:    r = s[47:40];
            3'd1:    r = s[39:32];
            3'd2:    r = s[31:24];
            3'd3:    r = s[23:16];
            3'd4:    r = s[15:8];
            3'd5:    r = s[7:0];
            default: r = 8'h0;
        endcase
        return r;
    endfunction

    // Drops every keyword whose text does not have byte c at position k.
    function automatic logic [NKEYS-1:0] narrow_keys(input logic [NKEYS-1:0] kw,
                                                     input logic [POS_W-1:0] k,
                                                     input logic [7:0] c);
        logic [NKEYS-1:0] r;
        logic             in_range;
        r = kw;
        for (int i = 0; i < NKEYS; i++) begin
            in_range = (k[POS_W-1:3] == '0) && (k[2:0] < KEY_LEN[i]);
            if (!(in_range && key_char(i, k[2:0]) == c))
            begin
                r[i] = 1'b0;
            end
        end
        return r;
    endfunction

    // The first surviving keyword of matching length names the kind.
    function automatic logic [KIND_W-1:0] ident_kind(input logic [NKEYS-1:0] kw,
                                                     input logic [POS_W-1:0] len);
        logic [KIND_W-1:0] r;
        r = K_IDENT;
        for (int i = NKEYS - 1; i >= 0; i--) begin
            if (kw[i] && len == POS_W'(KEY_LEN[i]))
            begin
                r = KEY_KIND[i];
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/elx_in_if.sv
// Input channel: one source byte or end marker per request.
`timescale 1ns / 1ps
interface elx_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] character;

    modport source (output valid, output opcode, output character, input ready);
    modport sink (input valid, input opcode, input character, output ready);
endinterface

>>> hdl/elx_out_if.sv
// Output channel: one token per request.
`timescale 1ns / 1ps
interface elx_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [1:0]  error_code;
    logic [19:0] start_offset;
    logic [19:0] token_length;
    logic [19:0] line_number;
    logic [19:0] column_number;
    logic        last;

    modport source (output valid, output token_kind, output error_code, output start_offset,
                    output token_length, output line_number, output column_number,
                    output last, input ready);
    modport sink (input valid, input token_kind, input error_code, input start_offset,
                  input token_length, input line_number, input column_number,
                  input last, output ready);
endinterface

>>> hdl/expression_language_lexer.sv
// Streaming lexer for a small bracketed expression language: top level.
//
// in_chan carries one request per source byte (opcode 0) and one end marker
// (opcode 1) per stream. out_chan carries one request per token with kind,
// error code, start offset, length, line and column; last marks the final
// token caused by one input request. One input request gives zero, one or two
// tokens.
// A byte is taken every cycle while the token queue has room. The first token
// of a byte passes through the queue and then the output register before it
// is presented on out_chan. The second token of a byte is loaded into the
// output register once the first is taken. Bytes that give two tokens
// therefore occupy the output register twice, which the queue absorbs.
// The lexer state updates once per byte in the front end; the output register
// accepts one token per cycle while out_chan.ready stays high.
// Reset clears the lexer to the start of a stream and empties the queue.
// When the receiver stalls, the output register holds its token, the queue
// fills, and in_chan.ready drops once QUEUE_DEPTH byte groups are waiting.
`timescale 1ns / 1ps
module expression_language_lexer #(
    parameter int MAX_INPUT_BYTES = elx_pkg::MAX_INPUT_BYTES_DEF,
    parameter int QUEUE_DEPTH = elx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    elx_in_if.sink    in_chan,
    elx_out_if.source out_chan
);
    import elx_pkg::*;

    elx_wr_t    wr;
    elx_qstat_t stat;
    logic       full;
    logic       pop;

    elx_front #(
        .MAX_INPUT_BYTES(MAX_INPUT_BYTES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_chan(in_chan),
        .full(full),
        .wr(wr)
    );

    elx_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .wr(wr),
        .pop(pop),
        .full(full),
        .stat(stat)
    );

    elx_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .stat(stat),
        .pop(pop),
        .out_chan(out_chan)
    );

endmodule

>>> hdl/elx_front.sv
// Lexer front end: one byte per cycle unless the queue is full; tracks positions, records tokens.
`timescale 1ns / 1ps
module elx_front #(
    parameter int MAX_INPUT_BYTES = elx_pkg::MAX_INPUT_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    elx_in_if.sink          in_chan,
    input  logic            full,
    output elx_pkg::elx_wr_t wr
);
    import elx_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = (MAX_INPUT_BYTES - 1 < 32'hFFFFF) ?
        POS_W'(MAX_INPUT_BYTES - 1) : {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    typedef enum logic [6:0] {
        M_IDLE  = 7'b0000001,
        M_MINUS = 7'b0000010,
        M_INT   = 7'b0000100,
        M_FRAC  = 7'b0001000,
        M_STR   = 7'b0010000,
        M_ESC   = 7'b0100000,
        M_IDENT = 7'b1000000
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [NKEYS-1:0] kw_reg, kw_next;
    logic [POS_W-1:0] tok_off_reg, tok_off_next;
    logic [POS_W-1:0] tok_line_reg, tok_line_next;
    logic [POS_W-1:0] tok_col_reg, tok_col_next;
    logic [POS_W-1:0] cur_off_reg, cur_off_next;
    logic [POS_W-1:0] cur_line_reg, cur_line_next;
    logic [POS_W-1:0] cur_col_reg, cur_col_next;
    logic             err_reg, err_next;

    logic             accept;
    logic [7:0]       c;
    logic [POS_W-1:0] k;
    logic [POS_W-1:0] off_inc;
    logic [POS_W-1:0] line_inc;
    logic [POS_W-1:0] col_inc;
    logic [KIND_W:0]  pk;
    logic             relex;
    logic             have_a;
    logic             have_b;
    elx_rec_t         rec_a;
    elx_rec_t         rec_b;
    elx_rec_t         r;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v >= POS_MAX) ? POS_MAX : v + POS_ONE;
    endfunction

    function automatic elx_rec_t make_rec(input logic [KIND_W-1:0] kind,
                                          input logic [CODE_W-1:0] code,
                                          input logic [POS_W-1:0] so,
                                          input logic [POS_W-1:0] eo,
                                          input logic one,
                                          input logic [POS_W-1:0] ln,
                                          input logic [POS_W-1:0] cl);
        elx_rec_t x;
        x.kind = kind;
        x.code = code;
        x.start_off = so;
        x.end_off = eo;
        x.len_one = one;
        x.line = ln;
        x.col = cl;
        return x;
    endfunction

    assign in_chan.ready = ~full;
    assign accept = in_chan.valid & ~full;
    assign c = in_chan.character;
    assign k = cur_off_reg - tok_off_reg;
    assign off_inc = sat_inc(cur_off_reg);
    assign line_inc = sat_inc(cur_line_reg);
    assign col_inc = sat_inc(cur_col_reg);
    assign pk = punct_kind(c);

    always_comb
    begin
        mode_next = mode_reg;
        kw_next = kw_reg;
        tok_off_next = tok_off_reg;
        tok_line_next = tok_line_reg;
        tok_col_next = tok_col_reg;
        cur_off_next = cur_off_reg;
        cur_line_next = cur_line_reg;
        cur_col_next = cur_col_reg;
        err_next = err_reg;
        relex = 1'b0;
        have_a = 1'b0;
        have_b = 1'b0;
        rec_a = '0;
        rec_b = '0;
        r = '0;

        if (accept && in_chan.opcode == OP_END)
        begin
            if (!err_reg)
            begin
                unique case (mode_reg)
                    M_MINUS, M_IDENT:
                    begin
                        rec_a = make_rec(ident_kind(kw_reg, k), ERR_NONE, tok_off_reg,
                                         cur_off_reg, 1'b0, tok_line_reg, tok_col_reg);
                        have_a = 1'b1;
                    end
                    M_INT, M_FRAC:
                    begin
                        rec_a = make_rec(K_NUMBER, ERR_NONE, tok_off_reg, cur_off_reg,
                                         1'b0, tok_line_reg, tok_col_reg);
                        have_a = 1'b1;
                    end
                    M_STR, M_ESC:
                    begin
                        rec_a = make_rec(K_ERROR, ERR_UNTERMINATED, tok_off_reg, cur_off_reg,
                                         1'b0, tok_line_reg, tok_col_reg);
                        have_a = 1'b1;
                    end
                    default:
                    begin
                        have_a = 1'b0;
                    end
                endcase
                if (!(mode_reg == M_STR || mode_reg == M_ESC))
                begin
                    r = make_rec(K_EOF, ERR_NONE, cur_off_reg, cur_off_reg, 1'b0,
                                 cur_line_reg, cur_col_reg);
                    if (have_a)
                    begin
                        rec_b = r;
                        have_b = 1'b1;
                    end
                    else
                    begin
                        rec_a = r;
                        have_a = 1'b1;
                    end
                end
            end
            // Every position returns to its reset value for the next stream.
            mode_next = M_IDLE;
            kw_next = '0;
            tok_off_next = '0;
            tok_line_next = POS_ONE;
            tok_col_next = POS_ONE;
            cur_off_next = '0;
            cur_line_next = POS_ONE;
            cur_col_next = POS_ONE;
            err_next = 1'b0;
        end
        else if (accept && !err_reg)
        begin
            // Continue the token in progress; relex marks a byte to be lexed as a new start.
            unique case (mode_reg)
                M_STR:
                begin
                    cur_off_next = off_inc;
                    cur_col_next = col_inc;
                    if (c == "\"")
                    begin
                        rec_a = make_rec(K_STRING, ERR_NONE, tok_off_reg, off_inc, 1'b0,
                                         tok_line_reg, tok_col_reg);
                        have_a = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else if (c == "\\")
                    begin
                        mode_next = M_ESC;
                    end
                end
                M_ESC:
                begin
                    cur_off_next = off_inc;
                    cur_col_next = col_inc;
                    mode_next = M_STR;
                end
                M_MINUS, M_IDENT:
                begin
                    if (mode_reg == M_MINUS && is_digit(c))
                    begin
                        cur_off_next = off_inc;
                        cur_col_next = col_inc;
                        mode_next = M_INT;
                    end
                    else if (ident_more(c))
                    begin
                        kw_next = narrow_keys(kw_reg, k, c);
                        cur_off_next = off_inc;
                        cur_col_next = col_inc;
                        mode_next = M_IDENT;
                    end
                    else
                    begin
                        rec_a = make_rec(ident_kind(kw_reg, k), ERR_NONE, tok_off_reg,
                                         cur_off_reg, 1'b0, tok_line_reg, tok_col_reg);
                        have_a = 1'b1;
                        mode_next = M_IDLE;
                        relex = 1'b1;
                    end
                end
                M_INT, M_FRAC:
                begin
                    if (is_digit(c))
                    begin
                        cur_off_next = off_inc;
                        cur_col_next = col_inc;
                    end
                    else if (mode_reg == M_INT && c == ".")
                    begin
                        cur_off_next = off_inc;
                        cur_col_next = col_inc;
                        mode_next = M_FRAC;
                    end
                    else
                    begin
                        rec_a = make_rec(K_NUMBER, ERR_NONE, tok_off_reg, cur_off_reg, 1'b0,
                                         tok_line_reg, tok_col_reg);
                        have_a = 1'b1;
                        mode_next = M_IDLE;
                        relex = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = M_IDLE;
                    relex = 1'b1;
                end
            endcase

            // The byte as a possible new token start; positions advance unless it is unexpected.
            if (relex)
            begin
                priority if (is_space(c))
                begin
                    cur_off_next = off_inc;
                    if (c == 8'h0A)
                    begin
                        cur_line_next = line_inc;
                        cur_col_next = POS_ONE;
                    end
                    else
                    begin
                        cur_col_next = col_inc;
                    end
                end
                else if (is_digit(c) || c == "-" || c == "\"" || ident_first(c))
                begin
                    tok_off_next = cur_off_reg;
                    tok_line_next = cur_line_reg;
                    tok_col_next = cur_col_reg;
                    cur_off_next = off_inc;
                    cur_col_next = col_inc;
                    priority if (is_digit(c))
                    begin
                        mode_next = M_INT;
                    end
                    else if (c == "-")
                    begin
                        mode_next = M_MINUS;
                        kw_next = '0;
                    end
                    else if (c == "\"")
                    begin
                        mode_next = M_STR;
                    end
                    else
                    begin
                        mode_next = M_IDENT;
                        kw_next = narrow_keys({NKEYS{1'b1}}, '0, c);
                    end
                end
                else
                begin
                    if (pk[KIND_W])
                    begin
                        r = make_rec(pk[KIND_W-1:0], ERR_NONE, cur_off_reg, cur_off_reg,
                                     1'b1, cur_line_reg, cur_col_reg);
                        cur_off_next = off_inc;
                        cur_col_next = col_inc;
                    end
                    else
                    begin
                        r = make_rec(K_ERROR, ERR_UNEXPECTED, cur_off_reg, cur_off_reg,
                                     1'b1, cur_line_reg, cur_col_reg);
                        err_next = 1'b1;
                    end
                    if (have_a)
                    begin
                        rec_b = r;
                        have_b = 1'b1;
                    end
                    else
                    begin
                        rec_a = r;
                        have_a = 1'b1;
                    end
                end
            end
        end
    end

    assign wr.push = accept & have_a;
    assign wr.entry.pair = have_b;
    assign wr.entry.rec0 = rec_a;
    assign wr.entry.rec1 = rec_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            kw_reg <= '0;
            tok_off_reg <= '0;
            tok_line_reg <= POS_ONE;
            tok_col_reg <= POS_ONE;
            cur_off_reg <= '0;
            cur_line_reg <= POS_ONE;
            cur_col_reg <= POS_ONE;
            err_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            kw_reg <= kw_next;
            tok_off_reg <= tok_off_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg <= tok_col_next;
            cur_off_reg <= cur_off_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg <= cur_col_next;
            err_reg <= err_next;
        end
    end

endmodule

>>> hdl/elx_fifo.sv
// Short queue of token groups between the lexer front end and the output stage.
`timescale 1ns / 1ps
module elx_fifo #(
    parameter int DEPTH = elx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  elx_pkg::elx_wr_t   wr,
    input  logic               pop,
    output logic               full,
    output elx_pkg::elx_qstat_t stat
);
    import elx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    elx_entry_t       slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CNT_FULL);
    assign do_push = wr.push & ~full;
    assign do_pop = pop & (count_reg != '0);
    assign stat.avail = (count_reg != '0);
    assign stat.head = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= wr.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> hdl/elx_back.sv
// Output stage: splits each token group into requests and finishes the token length.
`timescale 1ns / 1ps
module elx_back (
    input  logic                clk,
    input  logic                rst_n,
    input  elx_pkg::elx_qstat_t stat,
    output logic                pop,
    elx_out_if.source           out_chan
);
    import elx_pkg::*;

    logic              valid_reg;
    logic              sel_reg, sel_next;
    logic [KIND_W-1:0] kind_reg;
    logic [CODE_W-1:0] code_reg;
    logic [POS_W-1:0]  off_reg;
    logic [POS_W-1:0]  len_reg, len_next;
    logic [POS_W-1:0]  line_reg;
    logic [POS_W-1:0]  col_reg;
    logic              last_reg;
    logic              load;
    logic              final_rec;
    elx_rec_t          rec;

    assign load = stat.avail & (~valid_reg | out_chan.ready);
    assign rec = sel_reg ? stat.head.rec1 : stat.head.rec0;
    assign final_rec = ~stat.head.pair | sel_reg;
    assign pop = load & final_rec;
    assign sel_next = load ? ~final_rec : sel_reg;
    assign len_next = rec.len_one ? POS_W'(1) : rec.end_off - rec.start_off;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_chan.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= rec.kind;
            code_reg <= rec.code;
            off_reg <= rec.start_off;
            len_reg <= len_next;
            line_reg <= rec.line;
            col_reg <= rec.col;
            last_reg <= final_rec;
        end
    end

    assign out_chan.valid = valid_reg;
    assign out_chan.token_kind = kind_reg;
    assign out_chan.error_code = code_reg;
    assign out_chan.start_offset = off_reg;
    assign out_chan.token_length = len_reg;
    assign out_chan.line_number = line_reg;
    assign out_chan.column_number = col_reg;
    assign out_chan.last = last_reg;

endmodule

>>> bench/tb_expression_language_lexer.sv
// Self-checking lexer testbench: directed and random byte streams against a token predictor.
`timescale 1ns / 1ps
module tb_expression_language_lexer;
    import elx_pkg::*;

    localparam int ITEM_TARGET = 1400;
    localparam int DRAIN_CYCLES = 40;
    localparam longint TIMEOUT_NS = 64'd20_000_000;
    localparam logic [POS_W-1:0] POS_LIMIT =
        (MAX_INPUT_BYTES_DEF - 1 < 20'hFFFFF) ? POS_W'(MAX_INPUT_BYTES_DEF - 1) : 20'hFFFFF;

    localparam logic [KIND_W-1:0] KIND_IF     = 5'd3;
    localparam logic [KIND_W-1:0] KIND_LAMBDA = 5'd4;
    localparam logic [KIND_W-1:0] KIND_LET    = 5'd5;
    localparam logic [KIND_W-1:0] KIND_IN     = 5'd6;
    localparam logic [KIND_W-1:0] KIND_END    = 5'd7;
    localparam logic [KIND_W-1:0] KIND_TRUE   = 5'd16;
    localparam logic [KIND_W-1:0] KIND_FALSE  = 5'd17;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [2:0] {
        LX_IDLE, LX_MINUS, LX_INT, LX_FRAC, LX_STR, LX_ESC, LX_IDENT
    } lex_mode_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] character;
    } src_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  off;
        logic [POS_W-1:0]  len;
        logic [POS_W-1:0]  line;
        logic [POS_W-1:0]  col;
        logic              last;
    } token_t;

    logic clk;
    logic rst_n;

    elx_in_if  in_chan();
    elx_out_if out_chan();

    expression_language_lexer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    src_item_t source_items[$];
    token_t    expected_tokens[$];
    int        mismatches;
    int        planned_items;
    int        in_gap;
    int        out_gap;
    int        calm_in;
    int        calm_out;

    // Predictor state.
    lex_mode_t        mode;
    logic [POS_W-1:0] tok_off, tok_line, tok_col;
    logic [POS_W-1:0] cur_off, cur_line, cur_col;
    logic             err_seen;
    logic             id_minus;
    logic [47:0]      word_tail;
    token_t           step_out[2];
    int               step_n;

    string ident_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_+*/<>?!";
    string ident_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_+*/<>?!0123456789-=";
    string punct_set  = "{}()[]:=";

    function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] v);
        return (v >= POS_LIMIT) ? POS_LIMIT : v + 1'b1;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic starts_word(input logic [7:0] c);
        return is_letter(c) || c == "_" || c == "+" || c == "*" || c == "/" ||
               c == "<" || c == ">" || c == "?" || c == "!";
    endfunction

    function automatic logic continues_word(input logic [7:0] c);
        return starts_word(c) || is_num(c) || c == "-" || c == "=";
    endfunction

    // Returns K_ERROR when the byte is not punctuation.
    function automatic logic [KIND_W-1:0] punct_of(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            ":":     k = K_COLON;
            "=":     k = K_EQUALS;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    // A word is a keyword only when its whole text matches; a leading minus never does.
    function automatic logic [KIND_W-1:0] word_kind();
        logic [POS_W-1:0]  n;
        logic [KIND_W-1:0] k;
        n = cur_off - tok_off;
        k = K_IDENT;
        if (!id_minus)
        begin
            case (n)
                20'd2:
                begin
                    if (word_tail[15:0] == "if") k = KIND_IF;
                    else if (word_tail[15:0] == "in") k = KIND_IN;
                end
                20'd3:
                begin
                    if (word_tail[23:0] == "let") k = KIND_LET;
                    else if (word_tail[23:0] == "end") k = KIND_END;
                end
                20'd4: if (word_tail[31:0] == "true") k = KIND_TRUE;
                20'd5: if (word_tail[39:0] == "false") k = KIND_FALSE;
                20'd6: if (word_tail[47:0] == "lambda") k = KIND_LAMBDA;
                default: k = K_IDENT;
            endcase
        end
        return k;
    endfunction

    task automatic restart_stream();
        mode = LX_IDLE;
        tok_off = '0;
        tok_line = 20'd1;
        tok_col = 20'd1;
        cur_off = '0;
        cur_line = 20'd1;
        cur_col = 20'd1;
        err_seen = 1'b0;
        id_minus = 1'b0;
        word_tail = '0;
    endtask

    task automatic emit_token(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                              input logic [POS_W-1:0] off, input logic [POS_W-1:0] len,
                              input logic [POS_W-1:0] line, input logic [POS_W-1:0] col);
        step_out[step_n] = '{kind, code, off, len, line, col, 1'b0};
        step_n++;
    endtask

    task automatic emit_open_token(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code);
        emit_token(kind, code, tok_off, cur_off - tok_off, tok_line, tok_col);
    endtask

    task automatic open_token();
        tok_off = cur_off;
        tok_line = cur_line;
        tok_col = cur_col;
    endtask

    task automatic step_pos();
        cur_off = bump(cur_off);
        cur_col = bump(cur_col);
    endtask

    // Works out the tokens that one accepted request causes and queues them.
    task automatic lex_request(input logic op, input logic [7:0] c);
        logic   consumed;
        token_t t;
        step_n = 0;
        consumed = 1'b0;
        if (op == OP_END)
        begin
            if (!err_seen)
            begin
                case (mode)
                    LX_MINUS, LX_IDENT: emit_open_token(word_kind(), ERR_NONE);
                    LX_INT, LX_FRAC:    emit_open_token(K_NUMBER, ERR_NONE);
                    LX_STR, LX_ESC:     emit_open_token(K_ERROR, ERR_UNTERMINATED);
                    default:            ;
                endcase
                if (mode != LX_STR && mode != LX_ESC)
                begin
                    emit_token(K_EOF, ERR_NONE, cur_off, '0, cur_line, cur_col);
                end
            end
            restart_stream();
        end
        else if (!err_seen)
        begin
            case (mode)
                LX_STR:
                begin
                    step_pos();
                    if (c == "\"")
                    begin
                        emit_open_token(K_STRING, ERR_NONE);
                        mode = LX_IDLE;
                    end
                    else if (c == "\\")
                    begin
                        mode = LX_ESC;
                    end
                    consumed = 1'b1;
                end
                LX_ESC:
                begin
                    step_pos();
                    mode = LX_STR;
                    consumed = 1'b1;
                end
                LX_MINUS, LX_IDENT:
                begin
                    if (mode == LX_MINUS && is_num(c))
                    begin
                        step_pos();
                        mode = LX_INT;
                        consumed = 1'b1;
                    end
                    else if (continues_word(c))
                    begin
                        word_tail = {word_tail[39:0], c};
                        step_pos();
                        mode = LX_IDENT;
                        consumed = 1'b1;
                    end
                    else
                    begin
                        emit_open_token(word_kind(), ERR_NONE);
                        mode = LX_IDLE;
                    end
                end
                LX_INT:
                begin
                    if (is_num(c) || c == ".")
                    begin
                        step_pos();
                        if (c == ".") mode = LX_FRAC;
                        consumed = 1'b1;
                    end
                    else
                    begin
                        emit_open_token(K_NUMBER, ERR_NONE);
                        mode = LX_IDLE;
                    end
                end
                LX_FRAC:
                begin
                    if (is_num(c))
                    begin
                        step_pos();
                        consumed = 1'b1;
                    end
                    else
                    begin
                        emit_open_token(K_NUMBER, ERR_NONE);
                        mode = LX_IDLE;
                    end
                end
                default: mode = LX_IDLE;
            endcase

            // The byte that ended a token is lexed again as a new start.
            if (!consumed)
            begin
                if (is_blank(c))
                begin
                    if (c == CH_NEWLINE)
                    begin
                        cur_off = bump(cur_off);
                        cur_line = bump(cur_line);
                        cur_col = 20'd1;
                    end
                    else
                    begin
                        step_pos();
                    end
                end
                else if (is_num(c))
                begin
                    open_token();
                    step_pos();
                    mode = LX_INT;
                end
                else if (c == "-")
                begin
                    open_token();
                    step_pos();
                    id_minus = 1'b1;
                    mode = LX_MINUS;
                end
                else if (c == "\"")
                begin
                    open_token();
                    step_pos();
                    mode = LX_STR;
                end
                else if (punct_of(c) != K_ERROR)
                begin
                    emit_token(punct_of(c), ERR_NONE, cur_off, 20'd1, cur_line, cur_col);
                    step_pos();
                end
                else if (starts_word(c))
                begin
                    open_token();
                    id_minus = 1'b0;
                    word_tail = {40'h0, c};
                    step_pos();
                    mode = LX_IDENT;
                end
                else
                begin
                    emit_token(K_ERROR, ERR_UNEXPECTED, cur_off, 20'd1, cur_line, cur_col);
                    err_seen = 1'b1;
                    mode = LX_IDLE;
                end
            end
        end
        for (int i = 0; i < step_n; i++)
        begin
            t = step_out[i];
            t.last = (i == step_n - 1);
            expected_tokens.push_back(t);
        end
    endtask

    // Mostly no idling, sometimes short gaps, rarely long ones; calm stretches have none.
    function automatic int idle_length(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 3)
        begin
            calm = $urandom_range(30, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_byte(input logic [7:0] c, input bit counted = 1'b1);
        src_item_t it;
        it.opcode = OP_BYTE;
        it.character = c;
        source_items.push_back(it);
        if (counted) planned_items++;
    endtask

    task automatic add_end();
        src_item_t it;
        it.opcode = OP_END;
        it.character = 8'($urandom);
        source_items.push_back(it);
        planned_items++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_char(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_blank();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0:       c = 8'd9;
            1:       c = CH_NEWLINE;
            2:       c = 8'd11;
            3:       c = 8'd12;
            4:       c = 8'd13;
            default: c = " ";
        endcase
        return c;
    endfunction

    function automatic string keyword_text(input int i);
        string s;
        case (i)
            0:       s = "if";
            1:       s = "lambda";
            2:       s = "let";
            3:       s = "in";
            4:       s = "end";
            5:       s = "true";
            default: s = "false";
        endcase
        return s;
    endfunction

    task automatic add_number();
        if ($urandom_range(0, 2) == 0) add_byte("-");
        repeat ($urandom_range(1, 4)) add_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0)
        begin
            add_byte(".");
            repeat ($urandom_range(0, 3)) add_byte(8'("0" + $urandom_range(0, 9)));
        end
    endtask

    // String body without the closing quote; escapes may hide a quote or a newline.
    task automatic add_string_body();
        logic [7:0] c;
        add_byte("\"");
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 19))
                0, 1:    begin add_byte("\\"); add_byte(8'($urandom)); end
                2:       add_byte(CH_NEWLINE);
                3, 4, 5:
                begin
                    c = 8'($urandom_range(1, 255));
                    if (c == "\"" || c == "\\") c = 8'hE9;
                    add_byte(c);
                end
                default:
                begin
                    c = 8'($urandom_range(32, 126));
                    if (c == "\"" || c == "\\") c = "q";
                    add_byte(c);
                end
            endcase
        end
    endtask

    task automatic add_stream();
        int n_tok;
        n_tok = $urandom_range(1, 12);
        for (int i = 0; i < n_tok; i++)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                // A random byte, then bytes the lexer ignores if that byte was an error.
                add_byte(8'($urandom));
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom), 1'b0);
                add_end();
                return;
            end
            case ($urandom_range(0, 6))
                0:
                begin
                    add_text(keyword_text($urandom_range(0, 6)));
                    if ($urandom_range(0, 3) == 0) add_byte(pick_char(ident_tail));
                end
                1:
                begin
                    add_byte(pick_char(ident_head));
                    repeat ($urandom_range(0, 6)) add_byte(pick_char(ident_tail));
                end
                2: add_number();
                3: begin add_string_body(); add_byte("\""); end
                4: add_byte(pick_char(punct_set));
                5: add_byte("-");
                default: repeat ($urandom_range(1, 3)) add_byte(pick_blank());
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                repeat ($urandom_range(1, 3)) add_byte(pick_blank());
            end
        end
        if ($urandom_range(0, 99) < 6) add_string_body();
        add_end();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Request driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_chan.valid <= 1'b0;
        end
        else
        begin
            if (in_chan.valid && in_chan.ready)
            begin
                lex_request(in_chan.opcode, in_chan.character);
            end
            if (!in_chan.valid || in_chan.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_chan.valid <= 1'b0;
                    in_chan.character <= 8'($urandom);
                end
                else if (source_items.size() > 0)
                begin
                    in_chan.valid <= 1'b1;
                    in_chan.opcode <= source_items[0].opcode;
                    in_chan.character <= source_items[0].character;
                    void'(source_items.pop_front());
                    in_gap = idle_length(calm_in);
                end
                else
                begin
                    in_chan.valid <= 1'b0;
                end
            end
        end
    end

    // Token monitor and checker.
    always @(posedge clk)
    begin
        token_t got;
        token_t want;
        if (!rst_n)
        begin
            out_chan.ready <= 1'b0;
        end
        else
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                got = '{out_chan.token_kind, out_chan.error_code, out_chan.start_offset,
                        out_chan.token_length, out_chan.line_number, out_chan.column_number,
                        out_chan.last};
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: unexpected token kind %0d at offset %0d",
                                 $realtime, got.kind, got.off);
                    end
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: token mismatch (expected/actual) %s",
                                     $realtime, $sformatf("kind %0d/%0d code %0d/%0d",
                                     want.kind, got.kind, want.code, got.code));
                            $display("    off %0d/%0d len %0d/%0d line %0d/%0d %s",
                                     want.off, got.off, want.len, got.len, want.line,
                                     got.line, $sformatf("col %0d/%0d last %0d/%0d",
                                     want.col, got.col, want.last, got.last));
                        end
                    end
                end
                out_gap = idle_length(calm_out);
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_chan.ready <= 1'b0;
            end
            else
            begin
                out_chan.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_chan.valid = 1'b0;
        in_chan.opcode = OP_BYTE;
        in_chan.character = 8'h00;
        out_chan.ready = 1'b0;
        mismatches = 0;
        planned_items = 0;
        in_gap = 0;
        out_gap = 0;
        calm_in = 0;
        calm_out = 0;
        restart_stream();

        // Keyword, minus number with fraction, and a closing paren that ends a number.
        add_text("if(-1.5)");
        add_end();
        // Lone minus, then a string whose escaped newline is open at the end marker.
        add_byte("-");
        add_byte(" ");
        add_byte("\"");
        add_byte("\\");
        add_byte(CH_NEWLINE);
        add_end();
        // Punctuation but no parentheses, a zero byte, a byte ignored after the error, then a silent end.
        add_text("{}[]:=");
        add_byte(8'h00);
        add_byte("a");
        add_end();

        while (planned_items < ITEM_TARGET) add_stream();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (source_items.size() != 0 || in_chan.valid) @(posedge clk);
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_tokens.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
